// File: design/assert_macros.svh
// assertion helpers, included by rational_accumulator_reduce
// both expect clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define CHK_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

// consequent holds in the same cycle as the antecedent
`define CHK_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// File: design/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Types and codes for the rational accumulator: beat layouts, operation
// and status codes, accumulator range.
// ----------------------------------------------------------------------------
package rar_pkg;

	localparam int ACC_BITS = 32;
	localparam int DW       = 64;

	localparam logic [1:0] FN_LOAD = 2'd0;
	localparam logic [1:0] FN_ADD  = 2'd1;
	localparam logic [1:0] FN_INC  = 2'd2;
	localparam logic [1:0] FN_DEC  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [31:0] operand_num;
		logic signed [31:0] operand_den;
	} op_beat_t;

	typedef struct packed {
		logic signed [31:0] result_num;
		logic [30:0]        result_den;
		logic               nonzero;
		logic [1:0]         status;
	} res_beat_t;

endpackage

// File: design/rar_gcd.sv
// ----------------------------------------------------------------------------
// rar_gcd
// Binary gcd unit: one shift or one compare-and-subtract per cycle on
// 64-bit magnitudes. done pulses for one cycle with the result on g.
// ----------------------------------------------------------------------------
module rar_gcd import rar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] a,
	input  logic [DW-1:0] b,
	output logic [DW-1:0] g,
	output logic          done
);

	logic [DW-1:0] u_q, v_q, g_q;
	logic [5:0]    k_q;
	logic          busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && (u_q == '0 || v_q == '0);
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (u_q == '0 || v_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			u_q <= a;
			v_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			if (u_q == '0 || v_q == '0) begin
				g_q <= (u_q | v_q) << k_q;
			end else if (!u_q[0] && !v_q[0]) begin
				u_q <= u_q >> 1;
				v_q <= v_q >> 1;
				k_q <= k_q + 6'd1;
			end else if (!u_q[0]) begin
				u_q <= u_q >> 1;
			end else if (!v_q[0]) begin
				v_q <= v_q >> 1;
			end else if (u_q >= v_q) begin
				u_q <= u_q - v_q;
			end else begin
				v_q <= v_q - u_q;
			end
		end
	end

	assign g    = g_q;
	assign done = done_q;

endmodule

// File: design/rar_div.sv
// ----------------------------------------------------------------------------
// rar_div
// Restoring divider, one quotient bit per cycle while busy.
// done pulses with the quotient on q after the last bit.
// ----------------------------------------------------------------------------
module rar_div import rar_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] n,
	input  logic [DW-1:0] d,
	output logic [DW-1:0] q,
	output logic          done
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] rem_q, quo_q, dsr_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= n;
			dsr_q <= d;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign q    = quo_q;
	assign done = done_q;

endmodule

// File: design/rational_accumulator_reduce.sv
// ----------------------------------------------------------------------------
// rational_accumulator_reduce
// Rational accumulator kept in lowest terms with a positive denominator.
//
// op channel (op_valid/op_stall/op) carries one operation per beat: load,
// add, increment or decrement. Every beat gives exactly one res beat with
// the accumulator after the operation and a status (ok, zero denominator,
// overflow); on an error the accumulator is left as it was.
// op_stall is high from acceptance until the result is loaded into the
// output register, so one operation is in flight at a time.
// The operations run on the shared binary gcd unit (one shift or subtract
// per cycle) and the shared restoring divider: load runs one gcd and two
// divides; add, increment and decrement run three gcds, six divides and
// three multiplies. A zero denominator skips the units and goes straight
// to the commit state.
// The result waits in the output register while res_stall is high; the
// next op beat is taken meanwhile, and its result waits until the register
// is free. Reset sets the accumulator to 0/1 and drops res_valid.
// ----------------------------------------------------------------------------
module rational_accumulator_reduce import rar_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_stall,
	input  op_beat_t  op,
	output logic      res_valid,
	input  logic      res_stall,
	output res_beat_t res
);

	typedef enum logic [14:0] {
		S_IDLE   = 15'h0001,
		S_G1     = 15'h0002,
		S_D1     = 15'h0004,
		S_D2     = 15'h0008,
		S_G2     = 15'h0010,
		S_D3     = 15'h0020,
		S_D4     = 15'h0040,
		S_M1     = 15'h0080,
		S_M2     = 15'h0100,
		S_M3     = 15'h0200,
		S_SUM    = 15'h0400,
		S_G3     = 15'h0800,
		S_D5     = 15'h1000,
		S_D6     = 15'h2000,
		S_COMMIT = 15'h4000
	} state_t;

	localparam logic [DW-1:0] HALF    = DW'(1) << (ACC_BITS - 1);
	localparam logic [DW-1:0] MAX_POS = HALF - DW'(1);

	function automatic logic [31:0] mag32(logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	state_t             state_q;
	logic               go_q, zero_q;
	logic [1:0]         func_q;
	logic               cneg_q, sneg_q;
	logic [DW-1:0]      cm_q, dm_q, g_q, bq_q, dq_q, t1_q, t2_q, den_q, sm_q;
	logic signed [31:0] acc_num_q;
	logic [30:0]        acc_den_q;
	logic               res_valid_q;
	res_beat_t          res_q;

	// operand decode
	logic [31:0] cn, cd;
	always_comb begin
		if (op.func == FN_LOAD || op.func == FN_ADD) begin
			cn = op.operand_num;
			cd = op.operand_den;
		end else begin
			cn = (op.func == FN_INC) ? 32'd1 : 32'hFFFF_FFFF;
			cd = 32'd1;
		end
	end

	// shared units
	logic          gcd_start, gcd_done, div_start, div_done;
	logic [DW-1:0] gcd_a, gcd_b, gcd_g, div_n, div_d, div_q;

	always_comb begin
		gcd_a = cm_q;
		gcd_b = dm_q;
		div_n = cm_q;
		div_d = g_q;
		case (state_q)
			S_G2: begin
				gcd_a = DW'(acc_den_q);
				gcd_b = dm_q;
			end
			S_G3: begin
				gcd_a = sm_q;
				gcd_b = den_q;
			end
			S_D2: div_n = dm_q;
			S_D3: div_n = DW'(acc_den_q);
			S_D4: div_n = dm_q;
			S_D5: div_n = sm_q;
			S_D6: div_n = den_q;
			default: ;
		endcase
	end

	assign gcd_start = go_q && (state_q == S_G1 || state_q == S_G2 || state_q == S_G3);
	assign div_start = go_q && !gcd_start;

	rar_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (gcd_a),
		.b      (gcd_b),
		.g      (gcd_g),
		.done   (gcd_done)
	);

	rar_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.n      (div_n),
		.d      (div_d),
		.q      (div_q),
		.done   (div_done)
	);

	// start pulse for the unit used by the next state
	logic go_d;
	always_comb begin
		go_d = 1'b0;
		unique case (state_q)
			S_IDLE: go_d = op_valid && (cd != '0);
			S_G1, S_G2, S_G3: go_d = gcd_done;
			S_D1, S_D3, S_D5: go_d = div_done;
			S_D2: go_d = div_done && (func_q != FN_LOAD);
			S_SUM: go_d = 1'b1;
			default: go_d = 1'b0;
		endcase
	end

	// multiplier, registered after each use
	logic [31:0]   am, mul_a, mul_b;
	logic [DW-1:0] prod;
	assign am = mag32(acc_num_q);
	always_comb begin
		case (state_q)
			S_M1: begin
				mul_a = am;
				mul_b = dq_q[31:0];
			end
			S_M2: begin
				mul_a = cm_q[31:0];
				mul_b = bq_q[31:0];
			end
			default: begin
				mul_a = bq_q[31:0];
				mul_b = dm_q[31:0];
			end
		endcase
	end
	assign prod = DW'(mul_a) * DW'(mul_b);

	// range check of the reduced candidate
	logic          c_neg, neg_eff, ovf;
	logic [DW-1:0] c_m, c_den;
	logic [1:0]    c_status;
	logic [31:0]   c_num;
	logic          commit_go;

	always_comb begin
		if (func_q == FN_LOAD) begin
			c_neg = cneg_q;
			c_m   = cm_q;
			c_den = dm_q;
		end else begin
			c_neg = sneg_q;
			c_m   = sm_q;
			c_den = den_q;
		end
		neg_eff = c_neg && (c_m != '0);
		ovf = (c_den == '0) || (c_den > MAX_POS)
			|| (neg_eff ? (c_m > HALF) : (c_m > MAX_POS));
		c_num = neg_eff ? (~c_m[31:0] + 32'd1) : c_m[31:0];
		if (zero_q) begin
			c_status = ST_ZERO_DEN;
		end else if (ovf) begin
			c_status = ST_OVERFLOW;
		end else begin
			c_status = ST_OK;
		end
	end

	assign commit_go = (state_q == S_COMMIT) && !(res_valid_q && res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			go_q        <= 1'b0;
			res_valid_q <= 1'b0;
			acc_num_q   <= '0;
			acc_den_q   <= 31'd1;
		end else begin
			go_q <= go_d;
			if (commit_go) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						if (cd == '0) begin
							state_q <= S_COMMIT;
						end else begin
							state_q <= S_G1;
						end
					end
				end
				S_G1: if (gcd_done) begin
					state_q <= S_D1;
				end
				S_D1: if (div_done) begin
					state_q <= S_D2;
				end
				S_D2: if (div_done) begin
					if (func_q == FN_LOAD) begin
						state_q <= S_COMMIT;
					end else begin
						state_q <= S_G2;
					end
				end
				S_G2: if (gcd_done) begin
					state_q <= S_D3;
				end
				S_D3: if (div_done) begin
					state_q <= S_D4;
				end
				S_D4: if (div_done) begin
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_SUM;
				S_SUM: begin
					state_q <= S_G3;
				end
				S_G3: if (gcd_done) begin
					state_q <= S_D5;
				end
				S_D5: if (div_done) begin
					state_q <= S_D6;
				end
				S_D6: if (div_done) begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: if (commit_go) begin
					state_q <= S_IDLE;
					if (c_status == ST_OK) begin
						acc_num_q <= c_num;
						acc_den_q <= c_den[30:0];
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (op_valid) begin
				func_q <= op.func;
				zero_q <= (cd == '0);
				cneg_q <= cn[31] ^ cd[31];
				cm_q   <= DW'(mag32(cn));
				dm_q   <= DW'(mag32(cd));
			end
			S_G1, S_G2, S_G3: if (gcd_done) g_q <= gcd_g;
			S_D1: if (div_done) cm_q <= div_q;
			S_D2: if (div_done) dm_q <= div_q;
			S_D3: if (div_done) bq_q <= div_q;
			S_D4: if (div_done) dq_q <= div_q;
			S_M1: t1_q <= prod;
			S_M2: t2_q <= prod;
			S_M3: den_q <= prod;
			S_SUM: begin
				if (acc_num_q[31] == cneg_q) begin
					sm_q   <= t1_q + t2_q;
					sneg_q <= acc_num_q[31];
				end else if (t1_q >= t2_q) begin
					sm_q   <= t1_q - t2_q;
					sneg_q <= acc_num_q[31];
				end else begin
					sm_q   <= t2_q - t1_q;
					sneg_q <= cneg_q;
				end
			end
			S_D5: if (div_done) sm_q <= div_q;
			S_D6: if (div_done) den_q <= div_q;
			S_COMMIT: if (commit_go) begin
				res_q.status <= c_status;
				if (c_status == ST_OK) begin
					res_q.result_num <= c_num;
					res_q.result_den <= c_den[30:0];
					res_q.nonzero    <= (c_num != '0);
				end else begin
					res_q.result_num <= acc_num_q;
					res_q.result_den <= acc_den_q;
					res_q.nonzero    <= (acc_num_q != '0);
				end
			end
			default: ;
		endcase
	end

	assign op_stall  = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

`include "assert_macros.svh"

	`CHK_ALWAYS(a_den_nonzero, acc_den_q != '0)
	`CHK_IMPL(a_nonzero_flag, res_valid, res.nonzero == (res.result_num != '0))
	`CHK_IMPL(a_res_from_commit, $rose(res_valid), $past(state_q == S_COMMIT))
	`CHK_IMPL(a_acc_hold_busy, state_q != S_IDLE && state_q != S_COMMIT, $stable(acc_num_q))

endmodule
